// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Every macro samples on i_clk and is
// disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ZB_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ZB_NEVER(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/core/zbcb_pkg.sv
package zbcb_pkg;

    localparam int MAP_BLOCKS  = 64;
    localparam int STORE_DEPTH = 16;
    localparam int WORD_W      = 32;
    localparam int BLK_W       = $clog2(MAP_BLOCKS);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    typedef logic [BLK_W-1:0]  t_key;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]  t_count;

    // Operation broadcast to every cell of the store chain
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_UPDATE
    } t_cell_opcode;

    typedef struct packed {
        t_cell_opcode code;
        t_key         key;
        t_word        value;
    } t_cell_op;

    // Contents of one cell as seen by its neighbors
    typedef struct packed {
        logic  valid;
        t_key  tag;
        t_word value;
    } t_entry;

endpackage

// File: rtl/core/zero_block_compressed_bitmap.sv
// Sparse bit set of MAP_BLOCKS 32-bit blocks; only nonzero blocks are held,
// in a chain of STORE_DEPTH cells kept sorted by block number.
// Input stream (s_axis): one command per transaction: set, clear or test a
// bit, write or read a whole block. Output stream (m_axis): one result per
// command with the test bit, the read block, the number of held blocks and
// a status (ok, index out of range, store full).
// The command is first looked up across all cells (S_LOOK), then applied to
// the chain (S_APPLY), which loads the result register. One command is in
// flight at a time and the input reopens after the apply step, so the block
// takes no new command until the last one is applied; the apply step closes
// the lookup-modify-shift loop.
// Inserting or removing a block moves every cell above it by one position
// in the same cycle, each cell taking its neighbor's contents.
// A finished result waits in the output register; while the receiver stalls
// the next command may be accepted and looked up, and it is applied only
// once the output register is free.
// Reset empties every cell and clears the count; no clearing pass is needed,
// the cell contents are masked by their valid bits.
module zero_block_compressed_bitmap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // cmd[2:0], bit_index[13:3], block_index[19:14], block_value[51:20]
    input  logic [55:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // bit_present[0], read_value[32:1], stored_count[37:33], status[39:38]
    output logic [39:0] o_m_axis_tdata
);

    `include "assert_macros.svh"

    localparam int DEPTH = zbcb_pkg::STORE_DEPTH;

    typedef enum logic [2:0] {
        CMD_SET   = 3'd0,
        CMD_CLEAR = 3'd1,
        CMD_TEST  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_APPLY
    } t_state;

    t_state                  r_state;
    logic [2:0]              r_cmd;
    zbcb_pkg::t_key          r_key;
    logic                    r_range;
    zbcb_pkg::t_word         r_mask;
    zbcb_pkg::t_word         r_value;
    zbcb_pkg::t_cell_opcode  r_code;
    zbcb_pkg::t_word         r_new;
    t_status                 r_status;
    logic                    r_present;
    zbcb_pkg::t_word         r_rval;
    zbcb_pkg::t_count        r_count;
    logic                    r_out_valid;
    logic                    r_out_present;
    zbcb_pkg::t_word         r_out_rval;
    zbcb_pkg::t_count        r_out_count;
    t_status                 r_out_status;

    logic                    w_in_accept;
    logic                    w_commit;
    logic [5:0]              w_raw_blk;
    zbcb_pkg::t_cell_op      w_cell_op;
    zbcb_pkg::t_entry        w_entry [DEPTH];
    logic [DEPTH-1:0]        w_after;
    logic [DEPTH-1:0]        w_hit;
    logic [DEPTH-1:0]        w_valid;
    logic                    w_hit_any;
    zbcb_pkg::t_word         w_old;
    zbcb_pkg::t_word         w_wr_value;
    logic                    w_wr_en;

    zbcb_pkg::t_cell_opcode  n_code;
    zbcb_pkg::t_word         n_new;
    t_status                 n_status;
    logic                    n_present;
    zbcb_pkg::t_word         n_rval;
    zbcb_pkg::t_count        n_count;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign w_commit        = (r_state == S_APPLY) && (!r_out_valid || i_m_axis_tready);

    // bit commands address block bit_index / 32
    assign w_raw_blk = ((i_s_axis_tdata[2:0] == CMD_SET) ||
                        (i_s_axis_tdata[2:0] == CMD_CLEAR) ||
                        (i_s_axis_tdata[2:0] == CMD_TEST)) ?
                       i_s_axis_tdata[13:8] : i_s_axis_tdata[19:14];

    assign w_cell_op = '{code:  (w_commit ? r_code : zbcb_pkg::OP_HOLD),
                         key:   r_key,
                         value: r_new};

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        zbcb_pkg::t_entry w_prev;
        zbcb_pkg::t_entry w_next;
        logic             w_prev_after;

        if (gi == 0) begin : g_first
            assign w_prev       = '0;
            assign w_prev_after = 1'b0;
        end else begin : g_mid
            assign w_prev       = w_entry[gi-1];
            assign w_prev_after = w_after[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_entry[gi+1];
        end

        zbcb_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_cell_op),
            .i_prev       (w_prev),
            .i_prev_after (w_prev_after),
            .i_next       (w_next),
            .o_entry      (w_entry[gi]),
            .o_after      (w_after[gi]),
            .o_hit        (w_hit[gi])
        );

        assign w_valid[gi] = w_entry[gi].valid;
    end

    // Collect the addressed block; absent blocks read as zero
    always_comb begin
        w_old = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_old = w_old | (w_entry[i].value & {zbcb_pkg::WORD_W{w_hit[i]}});
        end
    end
    assign w_hit_any = |w_hit;

    // Decode the command against the looked-up block
    always_comb begin
        n_present  = 1'b0;
        n_rval     = '0;
        n_status   = ST_OK;
        w_wr_en    = 1'b0;
        w_wr_value = '0;
        case (r_cmd)
            CMD_SET: begin
                w_wr_en    = 1'b1;
                w_wr_value = w_old | r_mask;
            end
            CMD_CLEAR: begin
                w_wr_en    = 1'b1;
                w_wr_value = w_old & ~r_mask;
            end
            CMD_TEST: begin
                n_present = |(w_old & r_mask);
            end
            CMD_WRITE: begin
                w_wr_en    = 1'b1;
                w_wr_value = r_value;
            end
            CMD_READ: begin
                n_rval = w_old;
            end
            default: begin
            end
        endcase

        n_code = zbcb_pkg::OP_HOLD;
        n_new  = w_wr_value;
        if (r_range && ((r_cmd == CMD_SET) || (r_cmd == CMD_CLEAR) ||
                        (r_cmd == CMD_TEST) || (r_cmd == CMD_WRITE) ||
                        (r_cmd == CMD_READ))) begin
            n_status  = ST_RANGE;
            n_present = 1'b0;
            n_rval    = '0;
        end else if (w_wr_en) begin
            if (w_wr_value == '0) begin
                if (w_hit_any) begin
                    n_code = zbcb_pkg::OP_REMOVE;
                end
            end else if (w_hit_any) begin
                n_code = zbcb_pkg::OP_UPDATE;
            end else if (r_count >= zbcb_pkg::t_count'(DEPTH)) begin
                n_status = ST_FULL;
            end else begin
                n_code = zbcb_pkg::OP_INSERT;
            end
        end
    end

    always_comb begin
        case (r_code)
            zbcb_pkg::OP_INSERT: n_count = r_count + zbcb_pkg::t_count'(1);
            zbcb_pkg::OP_REMOVE: n_count = r_count - zbcb_pkg::t_count'(1);
            default:             n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a new result or drop the one the receiver took
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_cmd   <= i_s_axis_tdata[2:0];
                        r_key   <= zbcb_pkg::t_key'(w_raw_blk);
                        r_range <= (32'(w_raw_blk) >= zbcb_pkg::MAP_BLOCKS);
                        r_mask  <= 32'h8000_0000 >> i_s_axis_tdata[7:3];
                        r_value <= i_s_axis_tdata[51:20];
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_code    <= n_code;
                    r_new     <= n_new;
                    r_status  <= n_status;
                    r_present <= n_present;
                    r_rval    <= n_rval;
                    r_state   <= S_APPLY;
                end
                S_APPLY: begin
                    // hold until the output register can take the result
                    if (w_commit) begin
                        r_count       <= n_count;
                        r_out_present <= r_present;
                        r_out_rval    <= r_rval;
                        r_out_count   <= n_count;
                        r_out_status  <= r_status;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_status, 5'(r_out_count), r_out_rval, r_out_present};

    `ZB_ASSERT(a_count_matches_cells, $countones(w_valid) == int'(r_count), "count mismatch")
    `ZB_NEVER(a_cells_packed, (w_valid & (w_valid + DEPTH'(1))) != '0, "cells not packed")
    `ZB_ASSERT(a_single_hit, $onehot0(w_hit), "block number held in more than one cell")
    `ZB_ASSERT(a_result_from_apply,
               $rose(r_out_valid) |-> $past(r_state == S_APPLY), "result without apply")

endmodule

// File: rtl/core/zbcb_cell.sv
module zbcb_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  zbcb_pkg::t_cell_op i_op,
    input  zbcb_pkg::t_entry   i_prev,
    input  logic               i_prev_after,
    input  zbcb_pkg::t_entry   i_next,
    output zbcb_pkg::t_entry   o_entry,
    output logic               o_after,
    output logic               o_hit
);

    logic           r_valid;
    zbcb_pkg::t_key r_tag;
    zbcb_pkg::t_word r_value;

    logic            n_valid;
    zbcb_pkg::t_key  n_tag;
    zbcb_pkg::t_word n_value;

    // An empty cell sorts after every block number
    assign o_hit   = r_valid && (r_tag == i_op.key);
    assign o_after = !r_valid || (r_tag > i_op.key);
    assign o_entry = '{valid: r_valid, tag: r_tag, value: r_value};

    always_comb begin
        n_valid = r_valid;
        n_tag   = r_tag;
        n_value = r_value;
        case (i_op.code)
            zbcb_pkg::OP_INSERT: begin
                if (o_after) begin
                    if (i_prev_after) begin
                        // shift up: take the lower neighbor
                        n_valid = i_prev.valid;
                        n_tag   = i_prev.tag;
                        n_value = i_prev.value;
                    end else begin
                        n_valid = 1'b1;
                        n_tag   = i_op.key;
                        n_value = i_op.value;
                    end
                end
            end
            zbcb_pkg::OP_REMOVE: begin
                // shift down from the removed slot upward
                if (o_hit || o_after) begin
                    n_valid = i_next.valid;
                    n_tag   = i_next.tag;
                    n_value = i_next.value;
                end
            end
            zbcb_pkg::OP_UPDATE: begin
                if (o_hit) begin
                    n_value = i_op.value;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag   <= n_tag;
        r_value <= n_value;
    end

endmodule

// File: sim/tb_top.sv
module tb_top;

    localparam logic [2:0] CMD_SET   = 3'd0;
    localparam logic [2:0] CMD_CLEAR = 3'd1;
    localparam logic [2:0] CMD_TEST  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int RANDOM_CMDS = 1450;
    localparam int WINDOW      = 24;

    typedef struct {
        logic [2:0]      cmd;
        logic [10:0]     bit_idx;
        logic [5:0]      blk_idx;
        zbcb_pkg::t_word value;
        bit              drain;
    } t_bitmap_cmd;

    // same layout as o_m_axis_tdata
    typedef struct packed {
        logic [1:0]       status;
        zbcb_pkg::t_count count;
        zbcb_pkg::t_word  rd_value;
        logic             present;
    } t_bitmap_resp;

    typedef enum {PH_FILL, PH_GROW, PH_SHRINK, PH_MIXED, PH_NOISE} t_phase;
    typedef enum {RX_OPEN, RX_COIN, RX_PATTERN, RX_CHOKED} t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // cmd[2:0], bit_index[13:3], block_index[19:14], block_value[51:20]
    logic [55:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // bit_present[0], read_value[32:1], stored_count[37:33], status[39:38]
    logic [39:0] o_m_axis_tdata;

    zero_block_compressed_bitmap dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Shadow of the bitmap: presence bits, dense block words, held count
    bit [zbcb_pkg::MAP_BLOCKS-1:0] map_bits;
    zbcb_pkg::t_word               store_words [zbcb_pkg::STORE_DEPTH];
    int unsigned                   held;

    t_bitmap_cmd  pending_cmds[$];
    t_bitmap_resp expected_results[$];
    t_bitmap_cmd  cur_cmd = '{default: 0};
    bit           cmd_taken;
    int           errors;
    int           results_seen;

    function automatic int unsigned rank_below(int unsigned blk);
        int unsigned r;
        r = 0;
        for (int i = 0; i < blk && i < zbcb_pkg::MAP_BLOCKS; i++)
            if (map_bits[i])
                r++;
        return r;
    endfunction

    function automatic zbcb_pkg::t_word stored_word(int unsigned blk);
        int unsigned r;
        if (blk >= zbcb_pkg::MAP_BLOCKS || !map_bits[blk])
            return '0;
        r = rank_below(blk);
        return (r < zbcb_pkg::STORE_DEPTH) ? store_words[r] : '0;
    endfunction

    function automatic logic [1:0] put_word(int unsigned blk, zbcb_pkg::t_word v);
        int unsigned r;
        r = rank_below(blk);
        if (v == '0) begin
            // remove: close the gap above this slot
            if (map_bits[blk] && held > 0) begin
                for (int unsigned i = r; i + 1 < held && i + 1 < zbcb_pkg::STORE_DEPTH; i++)
                    store_words[i] = store_words[i + 1];
                held--;
            end
            map_bits[blk] = 1'b0;
            return ST_OK;
        end
        if (map_bits[blk]) begin
            if (r < zbcb_pkg::STORE_DEPTH)
                store_words[r] = v;
            return ST_OK;
        end
        if (held >= zbcb_pkg::STORE_DEPTH || r >= zbcb_pkg::STORE_DEPTH)
            return ST_FULL;
        for (int unsigned i = held; i > r; i--)
            store_words[i] = store_words[i - 1];
        store_words[r] = v;
        held++;
        map_bits[blk] = 1'b1;
        return ST_OK;
    endfunction

    function automatic t_bitmap_resp bitmap_response(t_bitmap_cmd c);
        t_bitmap_resp    rsp;
        int unsigned     blk;
        zbcb_pkg::t_word mask;
        zbcb_pkg::t_word old;
        rsp = '0;
        case (c.cmd)
            CMD_SET, CMD_CLEAR, CMD_TEST: begin
                blk  = 32'(c.bit_idx[10:5]);
                // bit 31 of a block is its first bit
                mask = zbcb_pkg::t_word'(1) << (5'd31 - c.bit_idx[4:0]);
                if (blk >= zbcb_pkg::MAP_BLOCKS) begin
                    rsp.status = ST_RANGE;
                end else begin
                    old = stored_word(blk);
                    if (c.cmd == CMD_SET)
                        rsp.status = put_word(blk, old | mask);
                    else if (c.cmd == CMD_CLEAR)
                        rsp.status = put_word(blk, old & ~mask);
                    else
                        rsp.present = |(old & mask);
                end
            end
            CMD_WRITE, CMD_READ: begin
                if (c.blk_idx >= zbcb_pkg::MAP_BLOCKS)
                    rsp.status = ST_RANGE;
                else if (c.cmd == CMD_WRITE)
                    rsp.status = put_word(32'(c.blk_idx), c.value);
                else
                    rsp.rd_value = stored_word(32'(c.blk_idx));
            end
            default: ;
        endcase
        rsp.count = zbcb_pkg::t_count'(held);
        return rsp;
    endfunction

    task automatic queue_cmd(logic [2:0] cmd, int bit_idx, int blk_idx,
                             zbcb_pkg::t_word value, bit drain);
        t_bitmap_cmd c;
        c.cmd     = cmd;
        c.bit_idx = 11'(bit_idx);
        c.blk_idx = 6'(blk_idx);
        c.value   = value;
        c.drain   = drain;
        pending_cmds.push_back(c);
    endtask

    function automatic zbcb_pkg::t_word pick_word(bit nonzero);
        zbcb_pkg::t_word v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            2:       v = zbcb_pkg::t_word'(1) << $urandom_range(0, 31);
            3:       v = 32'h8000_0001;
            default: v = $urandom;
        endcase
        if (nonzero && v == '0)
            v = zbcb_pkg::t_word'(1) << $urandom_range(0, 31);
        return v;
    endfunction

    task automatic flag_error(string msg);
        $display("ERROR at %0t, result %0d: %s", $time, results_seen, msg);
        errors++;
    endtask

    initial begin : build_stimulus
        int     order[$];
        int     made;
        int     len;
        int     base;
        int     blk;
        int     pos;
        int     fills;
        int     pick;
        bit     first;
        bit     drain;
        t_phase ph;

        queue_cmd(CMD_READ, 0, 0, '0, 1'b1);
        queue_cmd(CMD_TEST, 0, 0, '0, 1'b0);
        queue_cmd(CMD_TEST, 2047, 0, '0, 1'b0);
        queue_cmd(CMD_SET, 0, 0, '0, 1'b0);
        queue_cmd(CMD_SET, 2047, 0, '0, 1'b0);
        queue_cmd(CMD_TEST, 0, 0, '0, 1'b0);
        queue_cmd(CMD_TEST, 2047, 0, '0, 1'b0);
        queue_cmd(CMD_READ, 0, 0, '0, 1'b0);
        queue_cmd(CMD_READ, 0, zbcb_pkg::MAP_BLOCKS - 1, '0, 1'b0);
        queue_cmd(CMD_CLEAR, 0, 0, '0, 1'b0);
        // clear inside an empty block, then write zero to an empty block
        queue_cmd(CMD_CLEAR, 100, 0, '0, 1'b0);
        queue_cmd(CMD_WRITE, 0, 5, '0, 1'b0);
        queue_cmd(CMD_WRITE, 0, 10, '1, 1'b0);
        queue_cmd(CMD_WRITE, 0, 10, 32'hA5A5_A5A5, 1'b0);
        queue_cmd(CMD_READ, 0, 10, '0, 1'b0);
        queue_cmd(CMD_WRITE, 0, 10, '0, 1'b0);
        queue_cmd(CMD_READ, 0, 10, '0, 1'b0);
        for (int k = CMD_READ + 1; k < 8; k++)
            queue_cmd(3'(k), (k == 7) ? 2047 : $urandom_range(0, 2047),
                      (k == 7) ? zbcb_pkg::MAP_BLOCKS - 1 : $urandom_range(0, 63),
                      (k == 7) ? '1 : $urandom, 1'b0);
        queue_cmd(CMD_WRITE, 0, zbcb_pkg::MAP_BLOCKS - 1, '0, 1'b0);
        queue_cmd(CMD_READ, 0, zbcb_pkg::MAP_BLOCKS - 1, '0, 1'b0);

        made  = 0;
        first = 1'b1;
        while (made < RANDOM_CMDS) begin
            ph    = first ? PH_FILL : t_phase'($urandom_range(0, 4));
            first = 1'b0;
            base  = $urandom_range(0, 63);
            len   = $urandom_range(20, 60);
            if (ph == PH_FILL) begin
                // more distinct nonzero blocks than the store holds: must hit full
                order.delete();
                for (int b = 0; b < zbcb_pkg::MAP_BLOCKS; b++)
                    order.push_back(b);
                order.shuffle();
                fills = $urandom_range(zbcb_pkg::STORE_DEPTH + 1, zbcb_pkg::STORE_DEPTH + 4);
                for (int i = 0; i < fills; i++) begin
                    if ($urandom_range(0, 1))
                        queue_cmd(CMD_WRITE, 0, order[i], pick_word(1'b1), i == 0);
                    else
                        queue_cmd(CMD_SET, order[i] * 32 + $urandom_range(0, 31), 0, '0,
                                  i == 0);
                end
                made += fills;
            end else begin
                for (int i = 0; i < len; i++) begin
                    blk   = (base + $urandom_range(0, WINDOW - 1)) % zbcb_pkg::MAP_BLOCKS;
                    pos   = blk * 32 + $urandom_range(0, 31);
                    pick  = $urandom_range(0, 9);
                    drain = (i == 0) && ($urandom_range(0, 2) == 0);
                    case (ph)
                        PH_GROW: begin
                            if (pick < 4)
                                queue_cmd(CMD_SET, pos, 0, '0, drain);
                            else if (pick < 7)
                                queue_cmd(CMD_WRITE, 0, blk, pick_word(1'b1), drain);
                            else if (pick == 7)
                                queue_cmd(CMD_TEST, pos, 0, '0, drain);
                            else if (pick == 8)
                                queue_cmd(CMD_READ, 0, blk, '0, drain);
                            else
                                queue_cmd(CMD_WRITE, 0, blk, pick_word(1'b0), drain);
                        end
                        PH_SHRINK: begin
                            if (pick < 4)
                                queue_cmd(CMD_CLEAR, pos, 0, '0, drain);
                            else if (pick < 7)
                                queue_cmd(CMD_WRITE, 0, blk, '0, drain);
                            else if (pick == 7)
                                queue_cmd(CMD_TEST, pos, 0, '0, drain);
                            else if (pick == 8)
                                queue_cmd(CMD_READ, 0, blk, '0, drain);
                            else
                                queue_cmd(CMD_WRITE, 0, blk, pick_word(1'b0), drain);
                        end
                        PH_MIXED:
                            queue_cmd(3'($urandom_range(CMD_SET, CMD_READ)), pos, blk,
                                      pick_word(1'b0), drain);
                        default:
                            queue_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 2047),
                                      $urandom_range(0, 63), $urandom, drain);
                    endcase
                    made++;
                end
            end
        end
    end

    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin : drive_cmds
        logic nxt_valid;
        nxt_valid = i_s_axis_tvalid && !cmd_taken;
        if (i_rst_n && !nxt_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_cmds.size() > 0 &&
                         !(pending_cmds[0].drain && expected_results.size() > 0)) begin
                cur_cmd   = pending_cmds.pop_front();
                nxt_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        i_s_axis_tvalid <= nxt_valid;
        i_s_axis_tdata  <= {4'b0, cur_cmd.value, cur_cmd.blk_idx, cur_cmd.bit_idx,
                            cur_cmd.cmd};
    end

    t_rx_mode    rx_mode    = RX_OPEN;
    int          mode_left  = 0;
    logic [31:0] rx_pattern = 32'h1;

    always @(negedge i_clk) begin : drive_ready
        logic rdy;
        if (mode_left == 0) begin
            rx_mode    = t_rx_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 300);
            rx_pattern = $urandom | 32'h1;
        end else begin
            mode_left--;
        end
        case (rx_mode)
            RX_OPEN: rdy = 1'b1;
            RX_COIN: rdy = 1'($urandom_range(0, 1));
            RX_PATTERN: begin
                rdy        = rx_pattern[0];
                rx_pattern = {rx_pattern[0], rx_pattern[31:1]};
            end
            default: rdy = ($urandom_range(0, 7) == 0);
        endcase
        i_m_axis_tready <= rdy;
    end

    always @(posedge i_clk) begin : check_results
        t_bitmap_resp got;
        t_bitmap_resp want;
        cmd_taken = 1'b0;
        if (i_rst_n) begin
            // check the output before queueing this edge's transaction
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata;
                if (expected_results.size() == 0) begin
                    flag_error($sformatf("result with nothing pending: %h", o_m_axis_tdata));
                end else begin
                    want = expected_results.pop_front();
                    if (got.present !== want.present)
                        flag_error($sformatf("bit_present %b, expected %b",
                                             got.present, want.present));
                    if (got.rd_value !== want.rd_value)
                        flag_error($sformatf("read_value %h, expected %h",
                                             got.rd_value, want.rd_value));
                    if (got.count !== want.count)
                        flag_error($sformatf("stored_count %0d, expected %0d",
                                             got.count, want.count));
                    if (got.status !== want.status)
                        flag_error($sformatf("status %0d, expected %0d",
                                             got.status, want.status));
                end
                results_seen++;
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                cmd_taken = 1'b1;
                expected_results.push_back(bitmap_response(cur_cmd));
            end
        end
    end

    initial begin : finish_run
        wait (i_rst_n);
        do
            @(posedge i_clk);
        while (pending_cmds.size() > 0 || i_s_axis_tvalid || expected_results.size() > 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
